// File: rtl/bfdh_pkg.sv
`timescale 1ns / 1ps
package bfdh_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_SEL_W = 6;

  localparam logic [63:0] MIX_MUL_A   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam int          MIX_SHIFT   = 33;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic REG_BIT_COUNT  = 1'b0;
  localparam logic REG_HASH_COUNT = 1'b1;

  localparam logic [16:0] BIT_COUNT_RESET  = 17'd65536;
  localparam logic [4:0]  HASH_COUNT_RESET = 5'd7;

  // remainder unit retires two dividend bits per step
  localparam int         RED_CNT_W = 5;
  localparam logic [4:0] RED_LAST  = 5'd31;

  typedef enum logic [1:0] {
    RED_H1,
    RED_H2,
    RED_ONES
  } red_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LL,
    OP_MUL_HL,
    OP_MUL_LH,
    OP_MUL_END,
    OP_H2,
    OP_RED_LOAD,
    OP_RED_STEP,
    OP_RED_STORE,
    OP_READ,
    OP_CHECK,
    OP_ADV_STEP,
    OP_ADV_WRAP,
    OP_CLEAR,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL_LL,
    ST_MUL_HL,
    ST_MUL_LH,
    ST_MUL_END,
    ST_H2,
    ST_RED_LOAD,
    ST_RED_STEP,
    ST_RED_STORE,
    ST_READ,
    ST_CHECK,
    ST_ADV_STEP,
    ST_ADV_WRAP,
    ST_CLEAR,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t   op;
    logic     const_b;
    red_sel_t red_sel;
    logic     add;
    logic     query;
  } dp_cmd_t;

  typedef struct packed {
    logic bit_clear;
    logic clr_last;
  } dp_status_t;

endpackage

// File: rtl/bfdh_ram.sv
`timescale 1ns / 1ps
module bfdh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bfdh_ctrl.sv
`timescale 1ns / 1ps
module bfdh_ctrl
  import bfdh_pkg::*;
#(
  parameter int MAX_HASHES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  input  logic [4:0] hash_count,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       in_stall,
  output logic       out_valid
);

  localparam int KW = $clog2(MAX_HASHES + 1);

  ctrl_state_t          state, state_next;
  logic                 pass_b;
  red_sel_t             red_sel;
  logic [RED_CNT_W-1:0] step_cnt;
  logic [KW-1:0]        probe_cnt;
  logic [KW-1:0]        k_eff;
  logic                 is_add;
  logic                 is_query;
  logic                 accept;
  logic                 out_load;
  logic                 probe_last;

  always_comb begin
    if (hash_count == '0) begin
      k_eff = KW'(1);
    end else if (int'(hash_count) > MAX_HASHES) begin
      k_eff = KW'(MAX_HASHES);
    end else begin
      k_eff = KW'(hash_count);
    end
  end

  assign accept     = in_valid && (state == ST_IDLE);
  assign out_load   = (state == ST_DONE) && (!out_valid || !out_stall);
  assign probe_last = (probe_cnt + KW'(1)) == k_eff;

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (kind)
            KIND_ADD, KIND_QUERY: state_next = ST_MUL_LL;
            KIND_CLEAR:           state_next = ST_CLEAR;
            default:              state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL_LL:  state_next = ST_MUL_HL;
      ST_MUL_HL:  state_next = ST_MUL_LH;
      ST_MUL_LH:  state_next = ST_MUL_END;
      ST_MUL_END: state_next = pass_b ? ST_H2 : ST_MUL_LL;
      ST_H2:      state_next = ST_RED_LOAD;
      ST_RED_LOAD: state_next = ST_RED_STEP;
      ST_RED_STEP: begin
        if (step_cnt == RED_LAST) state_next = ST_RED_STORE;
      end
      ST_RED_STORE: state_next = (red_sel == RED_ONES) ? ST_READ : ST_RED_LOAD;
      ST_READ:      state_next = ST_CHECK;
      ST_CHECK: begin
        if ((is_query && status.bit_clear) || probe_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_ADV_STEP;
        end
      end
      ST_ADV_STEP: state_next = ST_ADV_WRAP;
      ST_ADV_WRAP: state_next = ST_READ;
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = OP_NONE;
    cmd.const_b = pass_b;
    cmd.red_sel = red_sel;
    cmd.add     = is_add;
    cmd.query   = (kind == KIND_QUERY);
    in_stall    = (state != ST_IDLE);
    case (state)
      ST_SWEEP:     cmd.op = OP_CLEAR;
      ST_IDLE:      cmd.op = accept ? OP_LOAD : OP_NONE;
      ST_MUL_LL:    cmd.op = OP_MUL_LL;
      ST_MUL_HL:    cmd.op = OP_MUL_HL;
      ST_MUL_LH:    cmd.op = OP_MUL_LH;
      ST_MUL_END:   cmd.op = OP_MUL_END;
      ST_H2:        cmd.op = OP_H2;
      ST_RED_LOAD:  cmd.op = OP_RED_LOAD;
      ST_RED_STEP:  cmd.op = OP_RED_STEP;
      ST_RED_STORE: cmd.op = OP_RED_STORE;
      ST_READ:      cmd.op = OP_READ;
      ST_CHECK:     cmd.op = OP_CHECK;
      ST_ADV_STEP:  cmd.op = OP_ADV_STEP;
      ST_ADV_WRAP:  cmd.op = OP_ADV_WRAP;
      ST_CLEAR:     cmd.op = OP_CLEAR;
      ST_DONE:      cmd.op = out_load ? OP_OUT : OP_NONE;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      pass_b    <= 1'b0;
      red_sel   <= RED_H1;
      step_cnt  <= '0;
      probe_cnt <= '0;
      is_add    <= 1'b0;
      is_query  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pass_b    <= 1'b0;
        red_sel   <= RED_H1;
        probe_cnt <= '0;
        is_add    <= (kind == KIND_ADD);
        is_query  <= (kind == KIND_QUERY);
      end
      if (state == ST_MUL_END) pass_b <= 1'b1;
      if (state == ST_RED_LOAD) step_cnt <= '0;
      if (state == ST_RED_STEP) step_cnt <= step_cnt + RED_CNT_W'(1);
      if (state == ST_RED_STORE) begin
        case (red_sel)
          RED_H1:  red_sel <= RED_H2;
          RED_H2:  red_sel <= RED_ONES;
          default: red_sel <= RED_ONES;
        endcase
      end
      if (state == ST_CHECK) probe_cnt <= probe_cnt + KW'(1);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_reset_sweeps: assert property (@(posedge clk) $fell(rst) |-> state == ST_SWEEP)
    else $error("store sweep not started after reset");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> probe_cnt < k_eff)
    else $error("probe count beyond hash count");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && out_stall |=> state == ST_DONE)
    else $error("result dropped while output stalled");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside done state");

endmodule

// File: rtl/bfdh_dpath.sv
`timescale 1ns / 1ps
module bfdh_dpath
  import bfdh_pkg::*;
#(
  parameter int MAX_BITS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [63:0] base_hash,
  input  logic [16:0] bit_count,
  output dp_status_t  status,
  output logic        might_contain
);

  localparam int MW          = $clog2(MAX_BITS + 1);
  localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW          = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;

  logic [MW-1:0]        m_eff;
  logic [63:0]          acc;
  logic                 carry;
  logic [63:0]          x;
  logic [63:0]          h2;
  logic [63:0]          prod;
  logic [63:0]          plo;
  logic [31:0]          cross_lo;
  logic [63:0]          shreg;
  logic [MW-1:0]        r;
  logic [MW-1:0]        pos;
  logic [MW-1:0]        r2;
  logic [MW-1:0]        w;
  logic                 hit;
  logic [AW-1:0]        clr_addr;

  logic [63:0]          mconst;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          mix_sum;
  logic [MW-1:0]        red_next;
  logic [MW-1:0]        w_calc;
  logic [MW-1:0]        pos_add;
  logic [MW-1:0]        pos_wrap;
  logic [AW-1:0]        word_idx;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rdata;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  always_comb begin
    if (bit_count == '0) begin
      m_eff = MW'(1);
    end else if (int'(bit_count) > MAX_BITS) begin
      m_eff = MW'(MAX_BITS);
    end else begin
      m_eff = MW'(bit_count);
    end
  end

  always_comb begin
    mconst = cmd.const_b ? MIX_MUL_B : MIX_MUL_A;
    case (cmd.op)
      OP_MUL_HL: begin
        mul_a = x[63:32];
        mul_b = mconst[31:0];
      end
      OP_MUL_LH: begin
        mul_a = x[31:0];
        mul_b = mconst[63:32];
      end
      default: begin
        mul_a = x[31:0];
        mul_b = mconst[31:0];
      end
    endcase
  end

  assign mix_sum = plo + {cross_lo + prod[31:0], 32'h0};

  // two restoring steps per cycle
  always_comb begin
    logic [MW:0] ra;
    logic [MW:0] rb;
    ra = {r, shreg[63]};
    if (ra >= {1'b0, m_eff}) ra = ra - {1'b0, m_eff};
    rb = {ra[MW-1:0], shreg[62]};
    if (rb >= {1'b0, m_eff}) rb = rb - {1'b0, m_eff};
    red_next = rb[MW-1:0];
  end

  // 2^64 mod m from (2^64 - 1) mod m
  always_comb begin
    logic [MW:0] rp1;
    rp1 = {1'b0, r} + (MW + 1)'(1);
    w_calc = (rp1 == {1'b0, m_eff}) ? '0 : rp1[MW-1:0];
  end

  always_comb begin
    logic [MW:0] sum;
    logic [MW:0] up;
    sum = {1'b0, pos} + {1'b0, r2};
    if (sum >= {1'b0, m_eff}) sum = sum - {1'b0, m_eff};
    pos_add = sum[MW-1:0];
    up = {1'b0, pos} + {1'b0, m_eff} - {1'b0, w};
    pos_wrap = (pos >= w) ? (pos - w) : up[MW-1:0];
  end

  assign word_idx  = AW'(pos >> BIT_SEL_W);
  assign mask      = WORD_BITS'(1) << pos[BIT_SEL_W-1:0];
  assign ram_we    = (cmd.op == OP_CLEAR) || ((cmd.op == OP_CHECK) && cmd.add);
  assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_addr : word_idx;
  assign ram_wdata = (cmd.op == OP_CLEAR) ? '0 : (rdata | mask);

  assign status.bit_clear = ~rdata[pos[BIT_SEL_W-1:0]];
  assign status.clr_last  = (clr_addr == AW'(STORE_WORDS - 1));

  bfdh_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(word_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_addr <= status.clr_last ? '0 : clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x   <= base_hash ^ (base_hash >> MIX_SHIFT);
        acc <= base_hash;
        hit <= cmd.query;
      end
      OP_MUL_LL: prod <= mul_a * mul_b;
      OP_MUL_HL: begin
        prod <= mul_a * mul_b;
        plo  <= prod;
      end
      OP_MUL_LH: begin
        prod     <= mul_a * mul_b;
        cross_lo <= prod[31:0];
      end
      OP_MUL_END: x <= mix_sum ^ (mix_sum >> MIX_SHIFT);
      OP_H2:      h2 <= (x == '0) ? GOLDEN_STEP : x;
      OP_RED_LOAD: begin
        r <= '0;
        case (cmd.red_sel)
          RED_H1:  shreg <= acc;
          RED_H2:  shreg <= h2;
          default: shreg <= '1;
        endcase
      end
      OP_RED_STEP: begin
        r     <= red_next;
        shreg <= shreg << 2;
      end
      OP_RED_STORE: begin
        case (cmd.red_sel)
          RED_H1:  pos <= r;
          RED_H2:  r2  <= r;
          default: w   <= w_calc;
        endcase
      end
      OP_CHECK: begin
        if (!cmd.add && status.bit_clear) hit <= 1'b0;
      end
      OP_ADV_STEP: begin
        {carry, acc} <= {1'b0, acc} + {1'b0, h2};
        pos          <= pos_add;
      end
      OP_ADV_WRAP: begin
        if (carry) pos <= pos_wrap;
      end
      OP_OUT:  might_contain <= hit;
      default: ;
    endcase
  end

endmodule

// File: rtl/bloom_filter_double_hash.sv
`timescale 1ns / 1ps
// channel  handshake             payload
// in       in_valid / in_stall   kind, base_hash
// out      out_valid / out_stall might_contain
// cfg      APB psel/penable      paddr, pwdata, prdata (bit_count @0, hash_count @4)
//
// Add/query: fmix64 on one 32x32 multiplier, then three 64-bit remainders
// (h1, h2, 2^64) in the 2-bit-per-cycle reducer, then per probe a read and a
// check, plus an advance and wrap step for all but the last, then the done state.
// Query stops at the first clear bit. Kind 3 goes from accept straight to done.
// Clear sweeps the store one word a cycle.
// Reset: the same sweep runs after reset; in_stall stays high until it ends.
// A finished beat waits in the output register while the next item is taken;
// that item then holds in its done state until the waiting beat leaves.
module bloom_filter_double_hash
  import bfdh_pkg::*;
#(
  parameter int MAX_BITS   = 65536,
  parameter int MAX_HASHES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] base_hash,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        might_contain,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0] bit_count;
  logic [4:0]  hash_count;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count  <= BIT_COUNT_RESET;
      hash_count <= HASH_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BIT_COUNT:  bit_count  <= pwdata[16:0];
        REG_HASH_COUNT: hash_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BIT_COUNT:  prdata = {15'h0, bit_count};
      REG_HASH_COUNT: prdata = {27'h0, hash_count};
      default:        prdata = '0;
    endcase
  end

  bfdh_ctrl #(
    .MAX_HASHES(MAX_HASHES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .hash_count(hash_count),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  bfdh_dpath #(
    .MAX_BITS(MAX_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .base_hash    (base_hash),
    .bit_count    (bit_count),
    .status       (status),
    .might_contain(might_contain)
  );

endmodule

// File: verif/bloom_filter_double_hash_test.sv
`timescale 1ns / 1ps
module bloom_filter_double_hash_test;
  import bfdh_pkg::*;

  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam logic [2:0]  ADDR_BITS     = {REG_BIT_COUNT, 2'b00};
  localparam logic [2:0]  ADDR_HASHES   = {REG_HASH_COUNT, 2'b00};
  localparam int          FILTER_BITS   = 65536;
  localparam int          PROBE_MAX     = 16;
  localparam logic [63:0] FMIX_C1       = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2       = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] STEP_FALLBACK = 64'h9e3779b97f4a7c15;
  localparam int          FMIX_SHIFT    = 33;
  localparam int          QUIET_LIMIT   = 20000;
  localparam int          CHUNK_ITEMS   = 123;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] value;
    logic [1:0]  op;
    logic [63:0] key;
    bit          typed;
    bit          answer;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [63:0] base_hash;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        might_contain;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // filter mirror and register copies
  bit [FILTER_BITS-1:0] mirror = '0;
  logic [16:0] cfg_bits = 17'd65536;
  logic [4:0]  cfg_hashes = 5'd7;

  bit   answers[$];
  bit   row_typed;
  bit   row_answer;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   errors = 0;
  int   quiet_cycles = 0;
  int   n_add = 0, n_query = 0, n_hit = 0, n_clear = 0, n_unused = 0, n_cfg = 0;

  bloom_filter_double_hash dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .base_hash(base_hash),
    .out_valid(out_valid), .out_stall(out_stall), .might_contain(might_contain),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic bit bloom_apply(input logic [1:0] op, input logic [63:0] h1);
    logic [63:0] step;
    logic [63:0] span;
    logic [63:0] probe;
    int unsigned probes;
    bit all_set;
    if (op == KIND_CLEAR) begin
      mirror = '0;
      return 1'b0;
    end
    if (op != KIND_ADD && op != KIND_QUERY) return 1'b0;
    step = h1 ^ (h1 >> FMIX_SHIFT);
    step = step * FMIX_C1;
    step = step ^ (step >> FMIX_SHIFT);
    step = step * FMIX_C2;
    step = step ^ (step >> FMIX_SHIFT);
    if (step == 64'd0) step = STEP_FALLBACK;
    if (cfg_bits == 17'd0) span = 64'd1;
    else if (cfg_bits > 17'(FILTER_BITS)) span = 64'(FILTER_BITS);
    else span = 64'(cfg_bits);
    if (cfg_hashes == 5'd0) probes = 1;
    else if (cfg_hashes > 5'(PROBE_MAX)) probes = PROBE_MAX;
    else probes = 32'(cfg_hashes);
    all_set = 1'b1;
    for (int unsigned i = 0; i < probes; i++) begin
      probe = (h1 + 64'(i) * step) % span;
      if (op == KIND_ADD) begin
        mirror[probe[15:0]] = 1'b1;
      end else if (!mirror[probe[15:0]]) begin
        all_set = 1'b0;
        break;
      end
    end
    return (op == KIND_QUERY) && all_set;
  endfunction

  always @(posedge clk) begin : monitor
    bit expected_bit;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          $display("%0t: beat with nothing expected, got %0b", $time, might_contain);
          errors++;
        end else begin
          expected_bit = answers.pop_front();
          if (might_contain !== expected_bit) begin
            $display("%0t: might_contain expected %0b, got %0b",
                     $time, expected_bit, might_contain);
            errors++;
          end
        end
        if (might_contain === 1'b1) n_hit++;
      end
      if (in_valid && !in_stall) begin
        expected_bit = bloom_apply(kind, base_hash);
        answers.push_back(row_typed ? row_answer : expected_bit);
        case (kind)
          KIND_ADD:   n_add++;
          KIND_QUERY: n_query++;
          KIND_CLEAR: n_clear++;
          default:    n_unused++;
        endcase
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic stim_row_t item_row(input logic [1:0] op, input logic [63:0] key,
                                         input bit typed, input bit answer);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.addr = '0;
    r.value = '0;
    r.op = op;
    r.key = key;
    r.typed = typed;
    r.answer = answer;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [2:0] addr, input logic [31:0] value);
    stim_row_t r;
    r = item_row(KIND_ADD, '0, 1'b0, 1'b0);
    r.is_cfg = 1'b1;
    r.addr = addr;
    r.value = value;
    return r;
  endfunction

  // entered and left just after a falling edge
  task automatic send_item(input logic [1:0] op, input logic [63:0] key,
                           input bit typed, input bit answer);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = op;
    base_hash = key;
    row_typed = typed;
    row_answer = answer;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write, then read back
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] want;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_BITS) cfg_bits = value[16:0];
    else if (addr == ADDR_HASHES) cfg_hashes = value[4:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (addr == ADDR_BITS) ? {15'd0, cfg_bits} : {27'd0, cfg_hashes};
    if (prdata !== want) begin
      $display("%0t: read-back at %0d expected %0h, got %0h", $time, addr, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    n_cfg++;
  endtask

  initial begin : stimulus
    stim_row_t script[$];
    logic [63:0] known_keys[$];
    logic [63:0] key;
    logic [31:0] bits_val;
    logic [31:0] hashes_val;
    int pick;

    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_ADD;
    base_hash = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_typed = 1'b0;
    row_answer = 1'b0;
    send_idle_pct = 23;
    recv_stall_pct = 57;

    // empty after reset, extremes, unused kind, clear
    script.push_back(item_row(KIND_QUERY, 64'h0, 1, 0));
    script.push_back(item_row(KIND_QUERY, '1, 1, 0));
    script.push_back(item_row(KIND_UNUSED, 64'h5555555555555555, 1, 0));
    script.push_back(item_row(KIND_ADD, 64'h0, 1, 0));
    script.push_back(item_row(KIND_QUERY, 64'h0, 1, 1));
    script.push_back(item_row(KIND_ADD, '1, 1, 0));
    script.push_back(item_row(KIND_QUERY, '1, 1, 1));
    script.push_back(item_row(KIND_QUERY, 64'h0123456789abcdef, 0, 0));
    script.push_back(item_row(KIND_CLEAR, 64'h0, 1, 0));
    script.push_back(item_row(KIND_QUERY, 64'h0, 1, 0));
    script.push_back(item_row(KIND_QUERY, '1, 1, 0));
    script.push_back(item_row(KIND_ADD, 64'haaaaaaaaaaaaaaaa, 1, 0));
    // zero counts act as one: every probe lands on bit 0
    script.push_back(cfg_row(ADDR_BITS, 32'd0));
    script.push_back(cfg_row(ADDR_HASHES, 32'd0));
    script.push_back(item_row(KIND_QUERY, 64'h1234, 0, 0));
    script.push_back(item_row(KIND_ADD, 64'h1234, 1, 0));
    script.push_back(item_row(KIND_QUERY, 64'hdeadbeef, 1, 1));
    // oversized counts clamp; store kept across the change
    script.push_back(cfg_row(ADDR_BITS, 32'hffffffff));
    script.push_back(cfg_row(ADDR_HASHES, 32'hffffffff));
    script.push_back(item_row(KIND_QUERY, 64'haaaaaaaaaaaaaaaa, 0, 0));
    script.push_back(item_row(KIND_ADD, 64'h0123456789abcdef, 1, 0));
    script.push_back(item_row(KIND_QUERY, 64'h0123456789abcdef, 1, 1));
    script.push_back(cfg_row(ADDR_BITS, 32'd64));
    script.push_back(cfg_row(ADDR_HASHES, 32'd16));
    script.push_back(item_row(KIND_QUERY, '1, 0, 0));
    script.push_back(item_row(KIND_ADD, 64'h8000000000000001, 1, 0));
    script.push_back(item_row(KIND_QUERY, 64'h8000000000000001, 1, 1));
    script.push_back(cfg_row(ADDR_BITS, 32'd1));
    script.push_back(cfg_row(ADDR_HASHES, 32'd1));
    script.push_back(item_row(KIND_QUERY, 64'h7fffffffffffffff, 0, 0));
    script.push_back(item_row(KIND_CLEAR, '1, 1, 0));
    script.push_back(item_row(KIND_QUERY, 64'h7fffffffffffffff, 1, 0));
    script.push_back(cfg_row(ADDR_BITS, 32'd65536));
    script.push_back(cfg_row(ADDR_HASHES, 32'd7));

    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        reg_write(script[i].addr, script[i].value);
      end else begin
        send_item(script[i].op, script[i].key, script[i].typed, script[i].answer);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 57 : 0;
      recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 23 : 0;
      for (int chunk = 0; chunk < 5; chunk++) begin
        drain();
        case ($urandom_range(5))
          0: bits_val = $urandom_range(256, 1);
          1: bits_val = $urandom_range(65536, 1);
          2: bits_val = 32'd65536;
          3: bits_val = $urandom_range(131071, 65537);
          4: bits_val = 32'd0;
          default: bits_val = $urandom_range(4096, 1);
        endcase
        hashes_val = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
        reg_write(ADDR_BITS, bits_val);
        reg_write(ADDR_HASHES, hashes_val);
        repeat (CHUNK_ITEMS) begin
          key = {$urandom, $urandom};
          if ($urandom_range(19) == 0) key = $urandom_range(1) ? '1 : '0;
          pick = $urandom_range(99);
          if (pick < 38) begin
            known_keys.push_back(key);
            if (known_keys.size() > 64) void'(known_keys.pop_front());
            send_item(KIND_ADD, key, 0, 0);
          end else if (pick < 94) begin
            if (pick < 76 && known_keys.size() != 0)
              key = known_keys[$urandom_range(known_keys.size() - 1)];
            send_item(KIND_QUERY, key, 0, 0);
          end else if (pick < 97) begin
            known_keys.delete();
            send_item(KIND_CLEAR, key, 0, 0);
          end else begin
            send_item(KIND_UNUSED, key, 0, 0);
          end
        end
      end
    end

    in_valid = 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d adds, %0d queries (%0d hits), %0d clears, %0d unused-kind beats",
             n_add, n_query, n_hit, n_clear, n_unused);
    $display("over %0d register writes with read-back and three idle/stall mixes", n_cfg);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bfdh_pkg.sv
rtl/bfdh_ram.sv
rtl/bfdh_ctrl.sv
rtl/bfdh_dpath.sv
rtl/bloom_filter_double_hash.sv
verif/bloom_filter_double_hash_test.sv
